// File: rtl/mlqs_pkg.sv
// Package for the multilevel queue slot scheduler: widths, codes, state type.
package mlqs_pkg;

    localparam int PID_W      = 8;
    localparam int PRIO_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int MAX_LEVELS = 2 ** PRIO_W;
    localparam int DATA_W     = 16;

    localparam int NUM_PRIO_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    typedef enum logic {
        FUNC_ENQUEUE  = 1'b0,
        FUNC_DISPATCH = 1'b1
    } mlqs_func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DISPATCHED = 2'd0,
        STAT_NOTHING    = 2'd1,
        STAT_ENQUEUED   = 2'd2,
        STAT_DROPPED    = 2'd3
    } mlqs_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_CHECK,
        S_SCAN,
        S_POP,
        S_READ,
        S_OUT
    } mlqs_state_t;

endpackage

// File: rtl/multilevel_queue_slot_scheduler.sv
// Multilevel queue scheduler with per-level FIFOs and priority time slots.
// Enqueue: the item passes through S_ENQ to S_OUT; an out-of-range level goes straight to S_OUT.
// Dispatch: S_CHECK, S_POP, S_READ, S_OUT when the current level still has slots and entries; otherwise
// S_SCAN steps through the levels by the shared count compare, at most min(NUM_PRIO, 8) of them.
// One item at a time: s_tready is high only while no item is in work or waiting on m_.
// aresetn (sync) clears counts, pointers and current level and sets the slot budget to NUM_PRIO; FIFO storage is not.
module multilevel_queue_slot_scheduler #(
    parameter int NUM_PRIO    = mlqs_pkg::NUM_PRIO_DEF,
    parameter int QUEUE_DEPTH = mlqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mlqs_pkg::DATA_W-1:0]   s_tdata,   // [7:0] process_id, [10:8] priority_req
    input  logic                          s_tuser,   // [0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mlqs_pkg::DATA_W-1:0]   m_tdata,   // [7:0] served_id, [10:8] served_level
    output logic [mlqs_pkg::STATUS_W-1:0] m_tuser    // [1:0] status
);
    import mlqs_pkg::*;

    // only levels reachable through a 3-bit priority can ever hold entries
    localparam int NLEV  = (NUM_PRIO < MAX_LEVELS) ? NUM_PRIO : MAX_LEVELS;
    localparam int LW    = $clog2(NLEV);
    localparam int IW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = $clog2(NUM_PRIO + 1);
    localparam int DEPTH = NLEV * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    mlqs_state_t  state_reg, state_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [LW-1:0] cur_lvl_reg, cur_lvl_next;
    logic [SW-1:0] slots_reg, slots_next;
    logic [IW-1:0] head_reg [NLEV];
    logic [IW-1:0] head_next [NLEV];
    logic [IW-1:0] tail_reg [NLEV];
    logic [IW-1:0] tail_next [NLEV];
    logic [CW-1:0] count_reg [NLEV];
    logic [CW-1:0] count_next [NLEV];
    logic [PID_W-1:0] pid_reg, pid_next;
    mlqs_status_t  status_reg, status_next;
    logic [PID_W-1:0] out_id_reg, out_id_next;
    logic [PRIO_W-1:0] out_lvl_reg, out_lvl_next;

    logic [PID_W-1:0] mem [DEPTH];
    logic [PID_W-1:0] rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [IW-1:0]    mem_idx;
    logic [AW-1:0]    mem_addr;

    logic [CW-1:0]     cnt_sel;
    logic [IW-1:0]     head_sel;
    logic [IW-1:0]     tail_sel;
    logic [PRIO_W-1:0] prio_in;
    logic              prio_bad;
    logic              accept;

    assign cnt_sel  = count_reg[lv_reg];
    assign head_sel = head_reg[lv_reg];
    assign tail_sel = tail_reg[lv_reg];
    assign prio_in  = s_tdata[PID_W +: PRIO_W];
    assign prio_bad = ({1'b0, prio_in} >= (PRIO_W + 1)'(NLEV));
    assign accept   = s_tvalid && s_tready;

    assign mem_idx  = (state_reg == S_ENQ) ? tail_sel : head_sel;
    assign mem_addr = AW'(lv_reg) * AW'(QUEUE_DEPTH) + AW'(mem_idx);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == FUNC_DISPATCH) state_next = S_CHECK;
                    else if (prio_bad)            state_next = S_OUT;
                    else                          state_next = S_ENQ;
                end
            end
            S_ENQ:   state_next = S_OUT;
            S_CHECK: begin
                if (slots_reg != '0 && cnt_sel != '0) state_next = S_POP;
                else                                  state_next = S_SCAN;
            end
            S_SCAN: begin
                if (cnt_sel != '0)                 state_next = S_POP;
                else if (lv_reg == LW'(NLEV - 1))  state_next = S_OUT;
            end
            S_POP:  state_next = S_READ;
            S_READ: state_next = S_OUT;
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_OUT);
        m_tuser  = status_reg;
        m_tdata  = {(DATA_W - PID_W - PRIO_W)'(0), out_lvl_reg, out_id_reg};
    end

    // datapath: one level looked up per cycle through lv_reg
    always_comb begin
        lv_next      = lv_reg;
        cur_lvl_next = cur_lvl_reg;
        slots_next   = slots_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        pid_next     = pid_reg;
        status_next  = status_reg;
        out_id_next  = out_id_reg;
        out_lvl_next = out_lvl_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pid_next     = s_tdata[PID_W-1:0];
                    out_id_next  = '0;
                    out_lvl_next = '0;
                    if (s_tuser == FUNC_DISPATCH) begin
                        lv_next = cur_lvl_reg;
                    end else if (prio_bad) begin
                        status_next = STAT_DROPPED;
                    end else begin
                        lv_next = prio_in[LW-1:0];
                    end
                end
            end
            S_ENQ: begin
                if (cnt_sel >= CW'(QUEUE_DEPTH)) begin
                    status_next = STAT_DROPPED;
                end else begin
                    mem_we             = 1'b1;
                    tail_next[lv_reg]  = (tail_sel == IW'(QUEUE_DEPTH - 1)) ? '0
                                         : tail_sel + IW'(1);
                    count_next[lv_reg] = cnt_sel + CW'(1);
                    status_next        = STAT_ENQUEUED;
                end
            end
            S_CHECK: begin
                if (!(slots_reg != '0 && cnt_sel != '0)) lv_next = '0;
            end
            S_SCAN: begin
                if (cnt_sel != '0) begin
                    slots_next = SW'(NUM_PRIO) - SW'(lv_reg);
                end else if (lv_reg == LW'(NLEV - 1)) begin
                    status_next  = STAT_NOTHING;
                    cur_lvl_next = '0;
                    slots_next   = SW'(NUM_PRIO);
                end else begin
                    lv_next = lv_reg + LW'(1);
                end
            end
            S_POP: begin
                mem_re             = 1'b1;
                head_next[lv_reg]  = (head_sel == IW'(QUEUE_DEPTH - 1)) ? '0
                                     : head_sel + IW'(1);
                count_next[lv_reg] = cnt_sel - CW'(1);
                slots_next         = slots_reg - SW'(1);
                cur_lvl_next       = lv_reg;
            end
            S_READ: begin
                status_next  = STAT_DISPATCHED;
                out_id_next  = rd_data_reg;
                out_lvl_next = PRIO_W'(lv_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= pid_reg;
        if (mem_re) rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            lv_reg      <= '0;
            cur_lvl_reg <= '0;
            slots_reg   <= SW'(NUM_PRIO);
            for (int i = 0; i < NLEV; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            lv_reg      <= lv_next;
            cur_lvl_reg <= cur_lvl_next;
            slots_reg   <= slots_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pid_reg     <= pid_next;
        status_reg  <= status_next;
        out_id_reg  <= out_id_next;
        out_lvl_reg <= out_lvl_next;
    end

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    a_slots_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slots_reg <= SW'(NUM_PRIO))
        else $error("slot budget above NUM_PRIO");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_sel <= CW'(QUEUE_DEPTH))
        else $error("level count above queue depth");

    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_DISPATCHED) |-> (m_tdata == '0))
        else $error("nonzero payload on a result that is not a dispatch");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |-> (cnt_sel != '0 && slots_reg != '0))
        else $error("pop from an empty level or with no slots");

endmodule

// File: dv/mlqs_monitor.sv
// Watches both channels of the scheduler, tracks its queues and checks every result item.
module mlqs_monitor #(
    parameter int NUM_PRIO    = mlqs_pkg::NUM_PRIO_DEF,
    parameter int QUEUE_DEPTH = mlqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [mlqs_pkg::DATA_W-1:0]   s_tdata,   // [7:0] process_id, [10:8] priority_req
    input  logic                          s_tuser,   // [0] func
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [mlqs_pkg::DATA_W-1:0]   m_tdata,   // [7:0] served_id, [10:8] served_level
    input  logic [mlqs_pkg::STATUS_W-1:0] m_tuser,   // [1:0] status
    output int                            fail_count,
    output int                            outstanding
);
    import mlqs_pkg::*;

    typedef struct packed {
        mlqs_status_t        status;
        logic [PID_W-1:0]    id;
        logic [PRIO_W-1:0]   level;
    } sched_outcome_t;

    logic [PID_W-1:0] level_fifo [NUM_PRIO][$];
    int               cur_level;
    int               slot_budget;
    sched_outcome_t   sched_outcomes [$];
    int               errors;

    function automatic sched_outcome_t schedule_item(input logic fn, input logic [PID_W-1:0] pid,
                                                     input logic [PRIO_W-1:0] prio);
        sched_outcome_t r;
        int             lvl;
        bit             found;
        r.status = STAT_NOTHING;
        r.id     = '0;
        r.level  = '0;
        if (fn == FUNC_ENQUEUE) begin
            if (int'(prio) >= NUM_PRIO || level_fifo[prio].size() >= QUEUE_DEPTH) begin
                r.status = STAT_DROPPED;
            end else begin
                level_fifo[prio].push_back(pid);
                r.status = STAT_ENQUEUED;
            end
        end else begin
            lvl   = cur_level % NUM_PRIO;
            found = (slot_budget > 0) && (level_fifo[lvl].size() > 0);
            // budget spent or level drained: rescan from the top level
            if (!found) begin
                for (int k = 0; k < NUM_PRIO; k++) begin
                    if (!found && level_fifo[k].size() > 0) begin
                        lvl         = k;
                        slot_budget = NUM_PRIO - k;
                        found       = 1'b1;
                    end
                end
            end
            if (found) begin
                cur_level = lvl;
                r.id      = level_fifo[lvl].pop_front();
                slot_budget--;
                r.level   = PRIO_W'(lvl);
                r.status  = STAT_DISPATCHED;
            end else begin
                cur_level   = 0;
                slot_budget = NUM_PRIO;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        sched_outcome_t want;
        sched_outcome_t got;
        if (!aresetn) begin
            for (int l = 0; l < NUM_PRIO; l++) level_fifo[l].delete();
            cur_level   = 0;
            slot_budget = NUM_PRIO;
            sched_outcomes.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                sched_outcomes.push_back(schedule_item(s_tuser, s_tdata[PID_W-1:0],
                                                       s_tdata[PID_W+PRIO_W-1:PID_W]));
            end
            if (m_tvalid && m_tready) begin
                got.status = mlqs_status_t'(m_tuser);
                got.id     = m_tdata[PID_W-1:0];
                got.level  = m_tdata[PID_W+PRIO_W-1:PID_W];
                if (sched_outcomes.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result item: status %0d id %0d level %0d",
                                 got.status, got.id, got.level);
                    errors++;
                end else begin
                    want = sched_outcomes.pop_front();
                    if (want.status !== got.status || want.id !== got.id ||
                        want.level !== got.level) begin
                        if (errors < 10)
                            $display("mismatch: expected status %0d id %0d level %0d, got %s",
                                     want.status, want.id, want.level,
                                     $sformatf("status %0d id %0d level %0d",
                                               got.status, got.id, got.level));
                        errors++;
                    end
                end
            end
        end
        fail_count  <= errors;
        outstanding <= sched_outcomes.size();
    end

endmodule

// File: dv/tb_top.sv
// Top of the scheduler testbench: clock, reset, item stimulus, ready shaping and verdict.
module tb_top;
    import mlqs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata  = '0;
    logic                s_tuser  = FUNC_ENQUEUE;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    bit idle_on = 1'b1;
    bit hold_off_req = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    multilevel_queue_slot_scheduler DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mlqs_monitor monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random ready bursts, one long hold-off on request, steady ready once idle_on is cleared
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!idle_on) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
    end

    task automatic send_item(input mlqs_func_t fn, input logic [PID_W-1:0] pid,
                             input logic [PRIO_W-1:0] prio);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {{(DATA_W-PID_W-PRIO_W){1'b0}}, prio, pid};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int         mode;
        int         focus;
        int         disp_pct;
        mlqs_func_t fn;
        logic [PID_W-1:0] pid;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty dispatch, fill one level past full, budget carry-over
        send_item(FUNC_DISPATCH, 8'($urandom), 3'($urandom));
        for (int i = 0; i < 17; i++) begin
            pid = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(i * 13);
            send_item(FUNC_ENQUEUE, pid, 3'd3);
        end
        send_item(FUNC_ENQUEUE, 8'hAA, 3'd7);
        send_item(FUNC_ENQUEUE, 8'h55, 3'd0);
        send_item(FUNC_DISPATCH, 8'hFF, 3'd7);
        send_item(FUNC_DISPATCH, 8'h00, 3'd0);
        // level 0 refills while level 3 still holds budget
        send_item(FUNC_ENQUEUE, 8'h01, 3'd0);
        send_item(FUNC_DISPATCH, 8'($urandom), 3'($urandom));
        send_item(FUNC_DISPATCH, 8'($urandom), 3'($urandom));
        drain_results();

        mode  = 0;
        focus = 0;
        for (int n = 0; n < 800; n++) begin
            if (n % 50 == 0) begin
                mode  = $urandom_range(0, 2);
                focus = $urandom_range(0, 7);
            end
            if (n == 100) hold_off_req = 1'b1;
            if (n == 400) drain_results();
            if (n == 650) idle_on = 1'b0;
            case (mode)
                0:       disp_pct = 15;   // fill levels, hit full queues
                1:       disp_pct = 80;   // drain, hit nothing-ready
                default: disp_pct = 45;
            endcase
            fn = ($urandom_range(0, 99) < disp_pct) ? FUNC_DISPATCH : FUNC_ENQUEUE;
            send_item(fn, 8'($urandom_range(0, 255)),
                      $urandom_range(0, 1) ? 3'(focus) : 3'($urandom_range(0, 7)));
        end

        drain_results();
        repeat (24) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
